### hdl/gscg_pkg.sv
// gscg_pkg: types, constants and GF(2) jump matrices for the scrambling code generator
// used by gscg_ctrl, gscg_dpath and gold_scrambling_code_generator_unit
`default_nettype none

package gscg_pkg;

  localparam int SEQ_W      = 18;
  localparam int JUMP_STEPS = 9;   // index bits 4..12 of the code index
  localparam int JCNT_W     = 4;
  localparam int CG_W       = 6;
  localparam int PC_W       = 3;
  localparam int CFG_IDX_W  = 2;

  typedef logic [SEQ_W-1:0] seq_t;
  // column j holds the image of unit vector j
  typedef logic [SEQ_W-1:0][SEQ_W-1:0] mat_t;
  typedef mat_t [JUMP_STEPS-1:0] jump_set_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SCR_GROUP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_SEL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 2'd2;

  localparam logic [CG_W-1:0]  SCR_GROUP_RESET    = 6'd63;
  localparam logic [PC_W-1:0]  CODE_SEL_RESET     = 3'd0;
  localparam seq_t             FRAME_LENGTH_RESET = 18'd38400;

  localparam seq_t SEED_X = 18'd1;
  localparam seq_t SEED_Y = 18'h3FFFF;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_JUMP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;   // seed the generators, latch the code index
    logic jump;   // one jump step: apply its matrix if the index bit is set
    logic emit;   // produce one chip and advance
  } cmd_t;

  typedef struct packed {
    logic frame_open;
    logic jump_last;
    logic out_valid;
  } status_t;

  typedef struct packed {
    logic [CG_W-1:0] scr_group;
    logic [PC_W-1:0] code_sel;
    seq_t            frame_length;
  } cfg_t;

  function automatic seq_t step_x(seq_t s);
    logic fb;
    fb = s[0] ^ s[7];
    return {fb, s[SEQ_W-1:1]};
  endfunction

  function automatic seq_t step_y(seq_t s);
    logic fb;
    fb = s[0] ^ s[5] ^ s[7] ^ s[10];
    return {fb, s[SEQ_W-1:1]};
  endfunction

  function automatic seq_t mat_apply(mat_t m, seq_t v);
    seq_t r;
    r = '0;
    for (int j = 0; j < SEQ_W; j++) begin
      if (v[j]) r = r ^ m[j];
    end
    return r;
  endfunction

  function automatic mat_t mat_mul(mat_t a, mat_t b);
    mat_t c;
    for (int j = 0; j < SEQ_W; j++) begin
      c[j] = mat_apply(a, b[j]);
    end
    return c;
  endfunction

  function automatic mat_t step_matrix(logic is_y);
    mat_t m;
    seq_t e;
    for (int j = 0; j < SEQ_W; j++) begin
      e    = seq_t'(1) << j;
      m[j] = is_y ? step_y(e) : step_x(e);
    end
    return m;
  endfunction

  // m raised to the power 2**k by repeated squaring
  function automatic mat_t mat_pow2(mat_t m, int k);
    mat_t r;
    r = m;
    for (int i = 0; i < k; i++) begin
      r = mat_mul(r, r);
    end
    return r;
  endfunction

  // x generator advanced 16 << k chips, k = 0 .. JUMP_STEPS-1
  function automatic jump_set_t build_jumps();
    jump_set_t js;
    mat_t      m;
    m = mat_pow2(step_matrix(1'b0), 4);
    for (int k = 0; k < JUMP_STEPS; k++) begin
      js[k] = m;
      m     = mat_mul(m, m);
    end
    return js;
  endfunction

  localparam jump_set_t X_JUMPS = build_jumps();

  // seeds advanced 131072 chips for the q branch
  localparam seq_t X_SEED_Q = mat_apply(mat_pow2(step_matrix(1'b0), 17), SEED_X);
  localparam seq_t Y_SEED_Q = mat_apply(mat_pow2(step_matrix(1'b1), 17), SEED_Y);

endpackage

`default_nettype wire

### hdl/gscg_ctrl.sv
// gscg_ctrl: sequencer for frame start (seed, index jump) and chip emission
// depends on gscg_pkg
`default_nettype none

module gscg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              restart,
  output logic                   in_ready,
  input  wire logic              out_ready,
  input  wire gscg_pkg::status_t status,
  output gscg_pkg::cmd_t         cmd
);

  gscg_pkg::state_t state;
  gscg_pkg::state_t state_next;

  logic slot_free;
  logic accept;
  logic need_start;

  assign slot_free  = !status.out_valid || out_ready;
  assign need_start = restart || !status.frame_open;
  assign accept     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gscg_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gscg_pkg::ST_RUN: begin
        if (accept && need_start) state_next = gscg_pkg::ST_JUMP;
      end
      gscg_pkg::ST_JUMP: begin
        if (status.jump_last) state_next = gscg_pkg::ST_EMIT;
      end
      gscg_pkg::ST_EMIT: begin
        if (slot_free) state_next = gscg_pkg::ST_RUN;
      end
      default: state_next = gscg_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      gscg_pkg::ST_RUN: begin
        in_ready = slot_free;
        cmd.load = accept && need_start;
        cmd.emit = accept && !need_start;
      end
      gscg_pkg::ST_JUMP: begin
        cmd.jump = 1'b1;
      end
      gscg_pkg::ST_EMIT: begin
        cmd.emit = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  a_ready_only_run: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == gscg_pkg::ST_RUN))
    else $error("input ready outside run state");

  a_jump_to_emit: assert property (@(posedge clk) disable iff (rst)
    (state == gscg_pkg::ST_JUMP && status.jump_last) |=> (state == gscg_pkg::ST_EMIT))
    else $error("jump sequence did not end in emit");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> slot_free)
    else $error("chip emitted into a full output register");

endmodule

`default_nettype wire

### hdl/gscg_dpath.sv
// gscg_dpath: generator registers, index jump unit, chip counter and output register
// depends on gscg_pkg
`default_nettype none

module gscg_dpath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire gscg_pkg::cmd_t    cmd,
  input  wire gscg_pkg::cfg_t    cfg,
  input  wire logic              out_ready,
  output gscg_pkg::status_t      status,
  output logic                   i_chip,
  output logic                   q_chip,
  output gscg_pkg::seq_t         chip_number,
  output logic                   frame_end
);

  gscg_pkg::seq_t x_state_i;
  gscg_pkg::seq_t y_state_i;
  gscg_pkg::seq_t x_state_q;
  gscg_pkg::seq_t y_state_q;
  gscg_pkg::seq_t chip_counter;
  logic           frame_open;
  logic           out_valid;

  logic [gscg_pkg::JUMP_STEPS-1:0] index_sh;
  logic [gscg_pkg::JCNT_W-1:0]     jcnt;

  gscg_pkg::mat_t jump_mat;
  logic           last;

  assign jump_mat = gscg_pkg::X_JUMPS[jcnt];
  assign last     = ({1'b0, chip_counter} + 19'd1) >= {1'b0, cfg.frame_length};

  assign status.frame_open = frame_open;
  assign status.jump_last  = (jcnt == gscg_pkg::JCNT_W'(gscg_pkg::JUMP_STEPS - 1));
  assign status.out_valid  = out_valid;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      out_valid  <= 1'b0;
      jcnt       <= '0;
    end else begin
      if (cmd.load) begin
        frame_open <= 1'b1;
        jcnt       <= '0;
      end else if (cmd.jump) begin
        jcnt <= jcnt + gscg_pkg::JCNT_W'(1);
      end else if (cmd.emit && last) begin
        frame_open <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // generators and chip counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_state_i    <= gscg_pkg::SEED_X;
      y_state_i    <= gscg_pkg::SEED_Y;
      x_state_q    <= gscg_pkg::X_SEED_Q;
      y_state_q    <= gscg_pkg::Y_SEED_Q;
      chip_counter <= '0;
      index_sh     <= {cfg.scr_group, cfg.code_sel};
    end else if (cmd.jump) begin
      if (index_sh[0]) begin
        x_state_i <= gscg_pkg::mat_apply(jump_mat, x_state_i);
        x_state_q <= gscg_pkg::mat_apply(jump_mat, x_state_q);
      end
      index_sh <= index_sh >> 1;
    end else if (cmd.emit) begin
      x_state_i <= gscg_pkg::step_x(x_state_i);
      y_state_i <= gscg_pkg::step_y(y_state_i);
      x_state_q <= gscg_pkg::step_x(x_state_q);
      y_state_q <= gscg_pkg::step_y(y_state_q);
      if (!last) chip_counter <= chip_counter + gscg_pkg::seq_t'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      i_chip      <= x_state_i[0] ^ y_state_i[0];
      q_chip      <= x_state_q[0] ^ y_state_q[0];
      chip_number <= chip_counter;
      frame_end   <= last;
    end
  end

  a_load_clears_count: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (chip_counter == '0 && frame_open))
    else $error("frame start did not clear the chip counter");

  a_last_closes_frame: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && last) |=> !frame_open)
    else $error("last chip did not close the frame");

  a_stall_holds_output: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(chip_number) && $stable(frame_end)))
    else $error("output register changed while stalled");

endmodule

`default_nettype wire

### hdl/gold_scrambling_code_generator_unit.sv
// gold_scrambling_code_generator_unit: top level of the downlink primary scrambling code generator
// depends on gscg_pkg, gscg_ctrl, gscg_dpath
`default_nettype none

// channel  | direction | signals                         | content
// ---------+-----------+---------------------------------+------------------------------
// s_       | in        | s_tvalid s_tready s_tdata[7:0]  | restart
// m_       | out       | m_tvalid m_tready m_tdata m_tlast| i/q chip, chip number, end
// cfg_     | in        | cfg_valid cfg_ready cfg_index   | register index and data
//
// a chip inside an open frame is emitted when accepted and shown on m_ the next cycle
// a chip that opens a frame (restart, or the chip after a frame end) is seeded,
//   then the x generators are jumped by the code index one matrix at a time in nine steps,
//   then the chip is emitted once the output register is free
// synchronous active-high reset, no clearing pass; the first chip always opens a frame
// m_ stalls hold the output register; a new transaction is taken while the register
//   is being drained in the same cycle

module gold_scrambling_code_generator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
  // master stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [0] i_chip, [1] q_chip, [19:2] chip_number, [23:20] zero
  output logic             m_tlast,   // frame_end
  // configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [17:0] cfg_data
);

  gscg_pkg::cfg_t    cfg;
  gscg_pkg::cmd_t    cmd;
  gscg_pkg::status_t status;

  logic           i_chip;
  logic           q_chip;
  gscg_pkg::seq_t chip_number;
  logic           frame_end;

  // configuration registers, writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scr_group    <= gscg_pkg::SCR_GROUP_RESET;
      cfg.code_sel     <= gscg_pkg::CODE_SEL_RESET;
      cfg.frame_length <= gscg_pkg::FRAME_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gscg_pkg::CFG_SCR_GROUP:    cfg.scr_group    <= cfg_data[gscg_pkg::CG_W-1:0];
        gscg_pkg::CFG_CODE_SEL:     cfg.code_sel     <= cfg_data[gscg_pkg::PC_W-1:0];
        gscg_pkg::CFG_FRAME_LENGTH: cfg.frame_length <= cfg_data;
        default: begin
          // unknown index, write ignored
        end
      endcase
    end
  end

  // frame sequencer
  gscg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .restart   (s_tdata[0]),
    .in_ready  (s_tready),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // generators and output register
  gscg_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .out_ready   (m_tready),
    .status      (status),
    .i_chip      (i_chip),
    .q_chip      (q_chip),
    .chip_number (chip_number),
    .frame_end   (frame_end)
  );

  assign m_tvalid = status.out_valid;
  assign m_tdata  = {4'b0000, chip_number, q_chip, i_chip};
  assign m_tlast  = frame_end;

endmodule

`default_nettype wire

### tb/testbench.sv
// testbench: self-checking bench for gold_scrambling_code_generator_unit
// depends on gscg_pkg (register indexes, sequence type) and the unit under test
`timescale 1ns / 1ps

module testbench;

  // expected content of one output transaction
  typedef struct packed {
    logic           i_chip;
    logic           q_chip;
    gscg_pkg::seq_t chip_number;
    logic           frame_end;
  } chip_t;

  // directed script: register writes and chips with typed-in counter and frame end
  typedef enum logic {ROW_CHIP, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t      kind;
    logic [1:0]     reg_idx;
    gscg_pkg::seq_t value;
    logic           restart;
    gscg_pkg::seq_t num;
    logic           last;
  } script_row_t;

  function automatic script_row_t cfg_row(logic [1:0] idx, gscg_pkg::seq_t val);
    return '{ROW_CFG, idx, val, 1'b0, '0, 1'b0};
  endfunction

  function automatic script_row_t chip_row(logic restart, gscg_pkg::seq_t num, logic last);
    return '{ROW_CHIP, gscg_pkg::CFG_SCR_GROUP, '0, restart, num, last};
  endfunction

  // after reset: group 63, code 0, 38400 chips per frame
  localparam script_row_t SCRIPT [32] = '{
    chip_row(1'b0, 18'd0, 1'b0),                // first chip opens a frame
    chip_row(1'b0, 18'd1, 1'b0),
    chip_row(1'b1, 18'd0, 1'b0),                // restart inside a frame
    cfg_row(gscg_pkg::CFG_FRAME_LENGTH, 18'd3), // shortened while the frame is open
    chip_row(1'b0, 18'd1, 1'b0),
    chip_row(1'b0, 18'd2, 1'b1),
    chip_row(1'b0, 18'd0, 1'b0),                // next tick after a frame end
    cfg_row(gscg_pkg::CFG_SCR_GROUP, 18'd0),    // code change only at next frame start
    cfg_row(gscg_pkg::CFG_CODE_SEL, 18'd7),
    chip_row(1'b0, 18'd1, 1'b0),
    chip_row(1'b0, 18'd2, 1'b1),
    chip_row(1'b0, 18'd0, 1'b0),
    cfg_row(gscg_pkg::CFG_FRAME_LENGTH, 18'd0), // zero length, counter already past it
    chip_row(1'b0, 18'd1, 1'b1),
    chip_row(1'b0, 18'd0, 1'b1),
    chip_row(1'b1, 18'd0, 1'b1),
    cfg_row(gscg_pkg::CFG_FRAME_LENGTH, 18'd1),
    chip_row(1'b1, 18'd0, 1'b1),
    chip_row(1'b0, 18'd0, 1'b1),
    cfg_row(gscg_pkg::CFG_SCR_GROUP, 18'd63),   // largest code index
    cfg_row(gscg_pkg::CFG_FRAME_LENGTH, 18'd5),
    chip_row(1'b1, 18'd0, 1'b0),
    chip_row(1'b0, 18'd1, 1'b0),
    chip_row(1'b0, 18'd2, 1'b0),
    chip_row(1'b0, 18'd3, 1'b0),
    chip_row(1'b0, 18'd4, 1'b1),
    cfg_row(gscg_pkg::CFG_SCR_GROUP, 18'd0),    // code index zero
    cfg_row(gscg_pkg::CFG_CODE_SEL, 18'd0),
    cfg_row(gscg_pkg::CFG_FRAME_LENGTH, 18'h3FFFF), // longest frame
    chip_row(1'b1, 18'd0, 1'b0),
    chip_row(1'b0, 18'd1, 1'b0),
    chip_row(1'b1, 18'd0, 1'b0)
  };

  localparam int             RANDOM_CHIPS = 900;
  localparam int             HOLD_CYCLES  = 400;
  localparam gscg_pkg::seq_t X_START      = 18'd1;
  localparam gscg_pkg::seq_t Y_START      = 18'h3FFFF;
  localparam int             Q_SHIFT      = 131072;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = gscg_pkg::CFG_SCR_GROUP;
  logic [17:0] cfg_data = 18'd0;

  gold_scrambling_code_generator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock
  always begin
    #2;
    clk = 1'b1;
    #2;
    clk = 1'b0;
  end

  // chips still owed by the block, oldest first
  chip_t chip_q[$];

  // predictor copy of the registers
  logic [gscg_pkg::CG_W-1:0] scr_group_r = 6'd63;
  logic [gscg_pkg::PC_W-1:0] code_sel_r  = 3'd0;
  gscg_pkg::seq_t            frame_len_r = 18'd38400;

  // predictor copy of the generators and the frame counter
  gscg_pkg::seq_t gx_i, gy_i, gx_q, gy_q;
  gscg_pkg::seq_t x_q_seed, y_q_seed;
  gscg_pkg::seq_t chip_cnt;
  logic frame_live = 1'b0;

  // pacing controls, written by the stimulus only
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int hold_asked = 0;

  // run statistics
  int fail_count = 0;
  int chips_checked = 0;
  int frame_ends_seen = 0;
  int frames_opened = 0;
  int cfg_writes = 0;
  int chips_sent = 0;

  // one chip of each generator: new element enters at the top
  function automatic gscg_pkg::seq_t x_shift(gscg_pkg::seq_t s);
    return {s[0] ^ s[7], s[17:1]};
  endfunction

  function automatic gscg_pkg::seq_t y_shift(gscg_pkg::seq_t s);
    return {s[0] ^ s[5] ^ s[7] ^ s[10], s[17:1]};
  endfunction

  // mostly back to back, sometimes a short gap, rarely a long gap
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // short frames most of the time so that many frame ends are seen
  function automatic gscg_pkg::seq_t pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return gscg_pkg::seq_t'($urandom_range(1, 40));
    else if (r < 70) return gscg_pkg::seq_t'($urandom_range(41, 300));
    else if (r < 80) return gscg_pkg::seq_t'($urandom_range(0, 1));
    else if (r < 90) return 18'd38400;
    else return gscg_pkg::seq_t'($urandom);
  endfunction

  // expected chip for one accepted restart flag; advances the predictor
  task automatic predict_chip(input logic restart, output chip_t res);
    int unsigned n;
    logic        ends;
    if (restart || !frame_live) begin
      // frame start: x jumps ahead by the code index on both branches
      n    = 128 * scr_group_r + 16 * code_sel_r;
      gx_i = X_START;
      gx_q = x_q_seed;
      repeat (n) begin
        gx_i = x_shift(gx_i);
        gx_q = x_shift(gx_q);
      end
      gy_i       = Y_START;
      gy_q       = y_q_seed;
      chip_cnt   = '0;
      frame_live = 1'b1;
      frames_opened++;
    end
    // frame length is checked on every chip, zero acts as one
    ends = (32'(chip_cnt) + 1) >= 32'(frame_len_r);
    res.i_chip      = gx_i[0] ^ gy_i[0];
    res.q_chip      = gx_q[0] ^ gy_q[0];
    res.chip_number = chip_cnt;
    res.frame_end   = ends;
    gx_i = x_shift(gx_i);
    gy_i = y_shift(gy_i);
    gx_q = x_shift(gx_q);
    gy_q = y_shift(gy_q);
    if (ends) frame_live = 1'b0;
    else chip_cnt = chip_cnt + 18'd1;
  endtask

  // offer one chip request after a gap, called and returning at a falling edge
  task automatic send_chip(input logic restart, input int gap, input logic typed,
                           input gscg_pkg::seq_t num, input logic last);
    chip_t want;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) begin
        s_tdata = {7'd0, 1'($urandom)};
        @(negedge clk);
      end
    end
    s_tvalid = 1'b1;
    s_tdata  = {7'd0, restart};
    do @(posedge clk); while (!s_tready);
    predict_chip(restart, want);
    if (typed) begin
      // counter and frame end as typed in the script
      want.chip_number = num;
      want.frame_end   = last;
    end
    chip_q = {chip_q, want};
    chips_sent++;
    @(negedge clk);
  endtask

  // register write, only once every owed chip has come out
  task automatic write_reg(input logic [1:0] idx, input gscg_pkg::seq_t val);
    s_tvalid = 1'b0;
    while (chip_q.size() != 0) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      gscg_pkg::CFG_SCR_GROUP:    scr_group_r = val[gscg_pkg::CG_W-1:0];
      gscg_pkg::CFG_CODE_SEL:     code_sel_r  = val[gscg_pkg::PC_W-1:0];
      gscg_pkg::CFG_FRAME_LENGTH: frame_len_r = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // stimulus: reset, directed script, then random phases
  initial begin : stimulus
    int             phase;
    int             rand_chips;
    int             phase_len;
    bit             with_hold;
    gscg_pkg::seq_t xs, ys;

    // q branch seeds: both generators 131072 chips past their starting states
    xs = X_START;
    ys = Y_START;
    repeat (Q_SHIFT) begin
      xs = x_shift(xs);
      ys = y_shift(ys);
    end
    x_q_seed = xs;
    y_q_seed = ys;

    repeat (9) @(negedge clk);
    rst = 1'b0;

    foreach (SCRIPT[k]) begin
      if (SCRIPT[k].kind == ROW_CFG) write_reg(SCRIPT[k].reg_idx, SCRIPT[k].value);
      else send_chip(SCRIPT[k].restart, pick_gap(), 1'b1, SCRIPT[k].num, SCRIPT[k].last);
    end

    phase      = 0;
    rand_chips = 0;
    while (rand_chips < RANDOM_CHIPS) begin
      // new settings between phases; a frame may still be open across them
      if (phase == 0) begin
        write_reg(gscg_pkg::CFG_SCR_GROUP, 18'd63);
        write_reg(gscg_pkg::CFG_CODE_SEL, 18'd7);
        write_reg(gscg_pkg::CFG_FRAME_LENGTH, 18'd1);
      end else if (phase == 1) begin
        write_reg(gscg_pkg::CFG_SCR_GROUP, 18'd0);
        write_reg(gscg_pkg::CFG_CODE_SEL, 18'd0);
        write_reg(gscg_pkg::CFG_FRAME_LENGTH, 18'd0);
      end else begin
        if ($urandom_range(0, 9) < 6)
          write_reg(gscg_pkg::CFG_SCR_GROUP, gscg_pkg::seq_t'($urandom_range(0, 63)));
        if ($urandom_range(0, 9) < 6)
          write_reg(gscg_pkg::CFG_CODE_SEL, gscg_pkg::seq_t'($urandom_range(0, 7)));
        if ($urandom_range(0, 9) < 7)
          write_reg(gscg_pkg::CFG_FRAME_LENGTH, pick_length());
      end

      // some phases run with no idling on one or both sides
      tx_calm   = ($urandom_range(0, 3) == 0);
      rx_calm   = ($urandom_range(0, 3) == 0);
      with_hold = (phase == 2);
      if (with_hold) begin
        // long output hold-off while requests keep coming
        tx_calm = 1'b1;
        hold_asked++;
      end

      phase_len = $urandom_range(30, 90);
      repeat (phase_len) begin
        send_chip($urandom_range(0, 99) < 4, tx_calm ? 0 : pick_gap(), 1'b0, '0, 1'b0);
        rand_chips++;
      end
      phase++;
    end

    // drain and watch for stray output transactions
    s_tvalid = 1'b0;
    while (chip_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);

    $display("run covered %0d chips over %0d frame starts and %0d frame ends,",
             chips_checked, frames_opened, frame_ends_seen);
    $display("%0d register writes, restarts, short and zero frames, one long output hold-off",
             cfg_writes);
    if (fail_count == 0 && chip_q.size() == 0) begin
      $display("gold_scrambling_code_generator_unit test passed");
    end else begin
      $display("gold_scrambling_code_generator_unit test failed");
    end
    $finish;
  end

  // output side: random stalls, calm stretches and one long hold-off on request
  initial begin : receiver
    int stall_left;
    int hold_given;
    stall_left = 0;
    hold_given = 0;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_given) begin
        hold_given = hold_asked;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
        if (!rx_calm) stall_left = pick_gap();
      end
    end
  end

  // output checker: each transaction against the oldest owed chip
  always @(posedge clk) begin
    chip_t got;
    chip_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.i_chip      = m_tdata[0];
      got.q_chip      = m_tdata[1];
      got.chip_number = m_tdata[19:2];
      got.frame_end   = m_tlast;
      chips_checked++;
      if (got.frame_end) frame_ends_seen++;
      if (chip_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected chip i=%0b q=%0b num=%0d end=%0b", $realtime,
                   got.i_chip, got.q_chip, got.chip_number, got.frame_end);
      end else begin
        want = chip_q.pop_front();
        if (got.i_chip != want.i_chip || got.q_chip != want.q_chip ||
            got.chip_number != want.chip_number || got.frame_end != want.frame_end) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"%0t: chip mismatch exp i=%0b q=%0b num=%0d end=%0b,",
                      " got i=%0b q=%0b num=%0d end=%0b"},
                     $realtime, want.i_chip, want.q_chip, want.chip_number, want.frame_end,
                     got.i_chip, got.q_chip, got.chip_number, got.frame_end);
        end
      end
    end
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #4000000;
    $display("gold_scrambling_code_generator_unit test failed");
    $finish;
  end

endmodule
